>>> sv/implicit_list_first_fit_allocator_macros.svh
`ifndef IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define IMPLICIT_LIST_FIRST_FIT_ALLOCATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ILFFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition holds at every edge out of reset
`define ILFFA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`endif

>>> sv/ilffa_pkg.sv
`timescale 1ns / 1ps
package ilffa_pkg;

    localparam int HEAP_BYTES_DEF = 4096;
    localparam int WORD_BYTES_DEF = 8;
    localparam int INIT_BREAK     = 64;
    localparam int REQ_W          = 13;
    localparam int PAY_W          = 12;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_WALK_CHK,
        S_GROW,
        S_MN,
        S_MN_CHK,
        S_MP,
        S_MP_CHK,
        S_PLACE,
        S_WRITE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        WM_SPLIT,
        WM_WHOLE,
        WM_FREE
    } t_wmode;

endpackage

>>> sv/ilffa_ram.sv
`timescale 1ns / 1ps
module ilffa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/implicit_list_first_fit_allocator.sv
`timescale 1ns / 1ps
// Boundary-tag heap allocator, first fit, one transaction in flight. All block tags sit in one
// single-port-read tag RAM, so an allocate or free walks the block list one block at a time
// (read, then check). A split takes four tag writes, other updates two. After reset the block
// writes the header and footer tags of the initial 64-byte free block and accepts no transaction
// until then. A result may wait in the output register while the next transaction is accepted.
module implicit_list_first_fit_allocator #(
    parameter int HEAP_BYTES = ilffa_pkg::HEAP_BYTES_DEF,
    parameter int WORD_BYTES = ilffa_pkg::WORD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // request_size[12:0], payload_address[24:13]
    input  logic [0:0]  i_s_tuser,  // kind[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // result_address[11:0], status[13:12]
);
    `include "implicit_list_first_fit_allocator_macros.svh"

    localparam int DEPTH = HEAP_BYTES / WORD_BYTES;
    localparam int IW    = $clog2(DEPTH);
    localparam int WS    = $clog2(WORD_BYTES);
    localparam int BW    = $clog2(HEAP_BYTES) + 1;
    localparam int AW    = (BW > 14 ? BW : 14) + 1;
    localparam logic [AW-1:0] C_W    = AW'(WORD_BYTES);
    localparam logic [AW-1:0] C_2W   = AW'(2 * WORD_BYTES);
    localparam logic [AW-1:0] C_MASK = AW'(WORD_BYTES - 1);
    localparam logic [AW-1:0] C_HEAP = AW'(HEAP_BYTES);

    ilffa_pkg::t_state  r_state, n_state;
    ilffa_pkg::t_wmode  r_wmode;
    ilffa_pkg::t_status r_res_status;
    logic [1:0]          r_wcnt;
    logic                r_init;
    logic                r_kind;
    logic [AW-1:0]       r_need, r_p, r_hdr, r_start, r_size;
    logic [BW-1:0]       r_brk;
    logic [ilffa_pkg::PAY_W-1:0] r_res_addr;
    logic                r_ovalid;
    logic [15:0]         r_odata;

    logic          w_re, w_we;
    logic [AW-1:0] w_raddr, w_waddr, w_wsize;
    logic          w_walloc;
    logic [BW-1:0] w_rdata;
    logic [AW-1:0] w_s, w_brk, w_next, w_need_in;
    logic          w_a, w_walk_go, w_bad_tag, w_fit, w_ovf, w_split, w_last, w_accept;
    logic          w_slot;

    ilffa_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_tags (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[WS +: IW]),
        .i_wdata (w_wsize[BW-1:0] | BW'(w_walloc)),
        .i_re    (w_re),
        .i_raddr (w_raddr[WS +: IW]),
        .o_rdata (w_rdata)
    );

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_need_in = ((AW'(i_s_tdata[ilffa_pkg::REQ_W-1:0]) + C_MASK) & ~C_MASK) + C_2W;
    assign w_s       = AW'({w_rdata[BW-1:WS], {WS{1'b0}}});
    assign w_a       = w_rdata[0];
    assign w_brk     = AW'(r_brk);
    assign w_next    = r_start + r_size;
    assign w_walk_go = (r_p < w_brk) && (r_kind == ilffa_pkg::KIND_ALLOC || r_p <= r_hdr);
    assign w_bad_tag = (w_s == '0) || (r_p + w_s > w_brk);
    assign w_fit     = !w_a && (w_s >= r_need);
    assign w_ovf     = (w_brk + r_need) > C_HEAP;
    assign w_split   = (r_size - r_need) >= C_2W;
    assign w_last    = (r_wmode == ilffa_pkg::WM_SPLIT) ? (r_wcnt == 2'd3) : (r_wcnt == 2'd1);
    assign w_slot    = !r_ovalid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ilffa_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser[0] == ilffa_pkg::KIND_FREE
                        && AW'(i_s_tdata[24:13]) < C_W) begin
                        n_state = ilffa_pkg::S_DONE;
                    end else begin
                        n_state = ilffa_pkg::S_WALK;
                    end
                end
            end
            ilffa_pkg::S_WALK: begin
                if (w_walk_go) begin
                    n_state = ilffa_pkg::S_WALK_CHK;
                end else if (r_kind == ilffa_pkg::KIND_ALLOC) begin
                    n_state = ilffa_pkg::S_GROW;
                end else begin
                    n_state = ilffa_pkg::S_DONE;
                end
            end
            ilffa_pkg::S_WALK_CHK: begin
                if (r_kind == ilffa_pkg::KIND_ALLOC) begin
                    if (w_bad_tag) n_state = ilffa_pkg::S_GROW;
                    else if (w_fit) n_state = ilffa_pkg::S_PLACE;
                    else n_state = ilffa_pkg::S_WALK;
                end else begin
                    if (w_bad_tag) n_state = ilffa_pkg::S_DONE;
                    else if (r_p == r_hdr) n_state = w_a ? ilffa_pkg::S_MN : ilffa_pkg::S_DONE;
                    else n_state = ilffa_pkg::S_WALK;
                end
            end
            ilffa_pkg::S_GROW: begin
                n_state = w_ovf ? ilffa_pkg::S_DONE : ilffa_pkg::S_MN;
            end
            ilffa_pkg::S_MN: begin
                n_state = (w_next < w_brk) ? ilffa_pkg::S_MN_CHK : ilffa_pkg::S_MP;
            end
            ilffa_pkg::S_MN_CHK: n_state = ilffa_pkg::S_MP;
            ilffa_pkg::S_MP: begin
                n_state = (r_start >= C_W) ? ilffa_pkg::S_MP_CHK : ilffa_pkg::S_PLACE;
            end
            ilffa_pkg::S_MP_CHK: n_state = ilffa_pkg::S_PLACE;
            ilffa_pkg::S_PLACE:  n_state = ilffa_pkg::S_WRITE;
            ilffa_pkg::S_WRITE: begin
                if (w_last) n_state = r_init ? ilffa_pkg::S_IDLE : ilffa_pkg::S_DONE;
            end
            ilffa_pkg::S_DONE: begin
                if (w_slot) n_state = ilffa_pkg::S_IDLE;
            end
            default: n_state = ilffa_pkg::S_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        w_re     = 1'b0;
        w_raddr  = r_p;
        w_we     = 1'b0;
        w_waddr  = r_start;
        w_wsize  = r_size;
        w_walloc = 1'b0;
        case (r_state)
            ilffa_pkg::S_WALK: w_re = w_walk_go;
            ilffa_pkg::S_MN: begin
                w_re    = w_next < w_brk;
                w_raddr = w_next;
            end
            ilffa_pkg::S_MP: begin
                w_re    = r_start >= C_W;
                w_raddr = r_start - C_W;
            end
            ilffa_pkg::S_WRITE: begin
                w_we = 1'b1;
                case (r_wmode)
                    ilffa_pkg::WM_SPLIT: begin
                        case (r_wcnt)
                            2'd0: begin
                                w_wsize = r_need; w_walloc = 1'b1;
                            end
                            2'd1: begin
                                w_waddr = r_start + r_need - C_W;
                                w_wsize = r_need; w_walloc = 1'b1;
                            end
                            2'd2: begin
                                w_waddr = r_start + r_need;
                                w_wsize = r_size - r_need;
                            end
                            default: begin
                                w_waddr = w_next - C_W;
                                w_wsize = r_size - r_need;
                            end
                        endcase
                    end
                    ilffa_pkg::WM_WHOLE: begin
                        w_walloc = 1'b1;
                        if (r_wcnt == 2'd1) w_waddr = w_next - C_W;
                    end
                    default: begin
                        if (r_wcnt == 2'd1) w_waddr = w_next - C_W;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == ilffa_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ilffa_pkg::S_WRITE;
            r_wmode  <= ilffa_pkg::WM_FREE;
            r_wcnt   <= '0;
            r_init   <= 1'b1;
            r_start  <= '0;
            r_size   <= AW'(ilffa_pkg::INIT_BREAK);
            r_brk    <= BW'(ilffa_pkg::INIT_BREAK);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ilffa_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_kind       <= i_s_tuser[0];
                        r_need       <= w_need_in;
                        r_hdr        <= AW'(i_s_tdata[24:13]) - C_W;
                        r_p          <= '0;
                        r_res_addr   <= '0;
                        r_res_status <= (i_s_tuser[0] == ilffa_pkg::KIND_FREE
                                         && AW'(i_s_tdata[24:13]) < C_W)
                                        ? ilffa_pkg::ST_BAD_FREE : ilffa_pkg::ST_OK;
                    end
                end
                ilffa_pkg::S_WALK: begin
                    if (!w_walk_go && r_kind == ilffa_pkg::KIND_FREE)
                        r_res_status <= ilffa_pkg::ST_BAD_FREE;
                end
                ilffa_pkg::S_WALK_CHK: begin
                    if (r_kind == ilffa_pkg::KIND_FREE && (w_bad_tag || (r_p == r_hdr && !w_a)))
                        r_res_status <= ilffa_pkg::ST_BAD_FREE;
                    r_start <= r_p;
                    r_size  <= w_s;
                    r_p     <= r_p + w_s;
                end
                ilffa_pkg::S_GROW: begin
                    if (w_ovf) begin
                        r_res_status <= ilffa_pkg::ST_OOM;
                    end else begin
                        r_start <= w_brk;
                        r_size  <= r_need;
                        r_brk   <= BW'(w_brk + r_need);
                    end
                end
                ilffa_pkg::S_MN_CHK: begin
                    if (!w_a && w_s != '0 && w_next + w_s <= w_brk) r_size <= r_size + w_s;
                end
                ilffa_pkg::S_MP_CHK: begin
                    if (!w_a && w_s != '0 && w_s <= r_start) begin
                        r_start <= r_start - w_s;
                        r_size  <= r_size + w_s;
                    end
                end
                ilffa_pkg::S_PLACE: begin
                    r_wcnt <= '0;
                    if (r_kind == ilffa_pkg::KIND_FREE) begin
                        r_wmode <= ilffa_pkg::WM_FREE;
                    end else begin
                        r_wmode    <= w_split ? ilffa_pkg::WM_SPLIT : ilffa_pkg::WM_WHOLE;
                        r_res_addr <= ilffa_pkg::PAY_W'(r_start + C_W);
                    end
                end
                ilffa_pkg::S_WRITE: begin
                    r_wcnt <= r_wcnt + 2'd1;
                    if (w_last) r_init <= 1'b0;
                end
                default: ;
            endcase
            if (r_state == ilffa_pkg::S_DONE && w_slot) begin
                r_ovalid <= 1'b1;
                r_odata  <= {2'b00, r_res_status, r_res_addr};
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `ILFFA_ASSERT_ALWAYS(a_brk_in_heap, i_clk, i_rst_n, AW'(r_brk) <= C_HEAP, "break past heap")
    `ILFFA_ASSERT_IMP(a_fail_no_addr, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[13:12] != ilffa_pkg::ST_OK, o_m_tdata[11:0] == '0, "failed result carries address")
    `ILFFA_ASSERT_IMP(a_ok_addr, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[13:12] == ilffa_pkg::ST_OK && o_m_tdata[11:0] != '0, AW'(o_m_tdata[11:0]) >= C_W, "payload below first word")
    `ILFFA_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == ilffa_pkg::S_IDLE, !w_we && !w_re, "tag ram busy while idle")
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int HEAP   = ilffa_pkg::HEAP_BYTES_DEF;
    localparam int WB     = ilffa_pkg::WORD_BYTES_DEF;
    localparam int NWORDS = HEAP / WB;
    localparam int N_RAND = 1150;
    localparam int N_DIR  = 17;
    localparam longint LIMIT = 64'd4000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;  // request_size[12:0], payload_address[24:13]
    logic [0:0]  i_s_tuser;  // kind[0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;  // result_address[11:0], status[13:12]

    implicit_list_first_fit_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    typedef struct packed {
        logic [11:0]        addr;
        ilffa_pkg::t_status status;
    } t_result;

    typedef struct {
        logic        kind;
        logic [12:0] req_size;
        logic [11:0] pay_addr;
        logic        has_exp;
        t_result     exp;
    } t_row;

    logic [31:0] heap_tags [NWORDS];
    logic [31:0] heap_top;
    t_result     pending_results [$];
    logic [11:0] live_blocks [$];
    int          mismatches;
    longint      cycles;
    bit          stall_rx;

    function automatic logic [31:0] tag_rd(logic [31:0] off);
        return (off / WB < NWORDS) ? heap_tags[off / WB] : 32'd0;
    endfunction

    function automatic void tag_wr(logic [31:0] off, logic [31:0] v);
        if (off / WB < NWORDS) heap_tags[off / WB] = v;
    endfunction

    function automatic void set_blk(logic [31:0] start, logic [31:0] sz, bit used);
        tag_wr(start, sz | used);
        if (sz >= WB) tag_wr(start + sz - WB, sz | used);
    endfunction

    function automatic logic [31:0] coalesce(logic [31:0] b);
        logic [31:0] sz, start, nxt, nt, ns, pt, ps;
        sz = tag_rd(b) & ~(WB - 1);
        start = b;
        nxt = b + sz;
        if (sz != 0 && nxt < heap_top) begin
            nt = tag_rd(nxt);
            ns = nt & ~(WB - 1);
            if (!nt[0] && ns != 0 && nxt + ns <= heap_top) sz += ns;
        end
        if (b >= WB) begin
            pt = tag_rd(b - WB);
            ps = pt & ~(WB - 1);
            if (!pt[0] && ps != 0 && ps <= b) begin
                start = b - ps;
                sz += ps;
            end
        end
        set_blk(start, sz, 1'b0);
        return start;
    endfunction

    function automatic void heap_reset();
        foreach (heap_tags[i]) heap_tags[i] = '0;
        heap_top = ilffa_pkg::INIT_BREAK;
        set_blk(0, ilffa_pkg::INIT_BREAK, 1'b0);
    endfunction

    function automatic t_result heap_step(logic kind, logic [12:0] req, logic [11:0] pay);
        t_result r;
        logic [31:0] need, p, t, s, orig, hdr;
        bit found, ok;
        r.addr = '0;
        r.status = ilffa_pkg::ST_OK;
        found = 0;
        ok = 0;
        if (kind == ilffa_pkg::KIND_ALLOC) begin
            need = ((32'(req) + WB - 1) & ~(WB - 1)) + 2 * WB;
            p = 0;
            while (p < heap_top) begin
                t = tag_rd(p);
                s = t & ~(WB - 1);
                if (s == 0 || p + s > heap_top) break;
                if (!t[0] && s >= need) begin
                    found = 1;
                    break;
                end
                p += s;
            end
            if (!found) begin
                if (heap_top + need > HEAP) begin
                    r.status = ilffa_pkg::ST_OOM;
                end else begin
                    p = heap_top;
                    heap_top += need;
                    set_blk(p, need, 1'b0);
                    p = coalesce(p);
                    found = 1;
                end
            end
            if (found) begin
                orig = tag_rd(p) & ~(WB - 1);
                if (orig >= need && orig - need >= 2 * WB) begin
                    set_blk(p + need, orig - need, 1'b0);
                    set_blk(p, need, 1'b1);
                end else begin
                    set_blk(p, orig, 1'b1);
                end
                r.addr = 12'(p + WB);
            end
        end else begin
            if (pay >= WB) begin
                hdr = pay - WB;
                p = 0;
                while (p < heap_top && p <= hdr) begin
                    t = tag_rd(p);
                    s = t & ~(WB - 1);
                    if (s == 0 || p + s > heap_top) break;
                    if (p == hdr) begin
                        ok = t[0];
                        break;
                    end
                    p += s;
                end
                if (ok) begin
                    set_blk(hdr, tag_rd(hdr) & ~(WB - 1), 1'b0);
                    void'(coalesce(hdr));
                end
            end
            if (!ok) r.status = ilffa_pkg::ST_BAD_FREE;
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver stall pattern: long open stretches and busy stretches
    initial begin
        stall_rx = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) == 0) stall_rx = ~stall_rx;
            i_m_tready <= stall_rx ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.addr   = o_m_tdata[11:0];
            got.status = ilffa_pkg::t_status'(o_m_tdata[13:12]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.addr !== want.addr || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr %h st %0d, got addr %h st %0d",
                                 want.addr, want.status, got.addr, got.status);
                end
            end
        end
    end

    task automatic send(logic kind, logic [12:0] req, logic [11:0] pay,
                        bit has_exp, t_result exp);
        t_result pred;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {7'd0, pay, req};
        do @(posedge i_clk); while (!o_s_tready);
        pred = heap_step(kind, req, pay);
        if (has_exp && pred !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees: exp %h pred %h", exp, pred);
        end
        pending_results.push_back(pred);
        if (kind == ilffa_pkg::KIND_ALLOC && pred.status == ilffa_pkg::ST_OK)
            live_blocks.push_back(pred.addr);
        if (kind == ilffa_pkg::KIND_FREE && pred.status == ilffa_pkg::ST_OK)
            foreach (live_blocks[i])
                if (live_blocks[i] == pay) begin
                    live_blocks.delete(i);
                    break;
                end
    endtask

    task automatic idle(int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    t_row dir_rows [N_DIR] = '{
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'd8,   1, '{12'd0, ilffa_pkg::ST_BAD_FREE}},
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'd0,   1, '{12'd0, ilffa_pkg::ST_BAD_FREE}},
        '{ilffa_pkg::KIND_ALLOC, 13'd0,    12'hfff, 1, '{12'd8, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_ALLOC, 13'd8191, 12'd0,   1, '{12'd0, ilffa_pkg::ST_OOM}},
        '{ilffa_pkg::KIND_ALLOC, 13'd4096, 12'd0,   1, '{12'd0, ilffa_pkg::ST_OOM}},
        '{ilffa_pkg::KIND_ALLOC, 13'd1,    12'd0,   0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_ALLOC, 13'd24,   12'd0,   0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'd12,  1, '{12'd0, ilffa_pkg::ST_BAD_FREE}},
        '{ilffa_pkg::KIND_FREE,  13'h1fff, 12'd24,  0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'd24,  1, '{12'd0, ilffa_pkg::ST_BAD_FREE}},
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'd8,   0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_ALLOC, 13'd100,  12'd0,   0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_ALLOC, 13'd2000, 12'd0,   0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'hfff, 1, '{12'd0, ilffa_pkg::ST_BAD_FREE}},
        '{ilffa_pkg::KIND_ALLOC, 13'd3000, 12'd0,   1, '{12'd0, ilffa_pkg::ST_OOM}},
        '{ilffa_pkg::KIND_ALLOC, 13'd7,    12'd0,   0, '{12'd0, ilffa_pkg::ST_OK}},
        '{ilffa_pkg::KIND_FREE,  13'd0,    12'hff8, 1, '{12'd0, ilffa_pkg::ST_BAD_FREE}}
    };

    initial begin
        int k, burst;
        logic [12:0] req;
        logic [11:0] pay;
        mismatches = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        heap_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send(dir_rows[i].kind, dir_rows[i].req_size, dir_rows[i].pay_addr,
                 dir_rows[i].has_exp, dir_rows[i].exp);
            if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 4));
        end
        drain();

        k = 0;
        while (k < N_RAND) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && k < N_RAND) begin
                if (k == N_RAND / 2) drain();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        req = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                          : 13'($urandom_range(0, 200));
                        send(ilffa_pkg::KIND_ALLOC, req, 12'($urandom), 0, '0);
                    end
                    4, 5, 6, 7: begin
                        if (live_blocks.size() != 0)
                            pay = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                        else
                            pay = 12'($urandom);
                        send(ilffa_pkg::KIND_FREE, 13'($urandom), pay, 0, '0);
                    end
                    8: send(ilffa_pkg::KIND_FREE, 13'($urandom), 12'($urandom), 0, '0);
                    default: begin
                        pay = (live_blocks.size() != 0) ? live_blocks[0] + 12'($urandom_range(1, 8))
                                                        : 12'($urandom);
                        send(ilffa_pkg::KIND_FREE, 13'($urandom), pay, 0, '0);
                    end
                endcase
                burst--;
                k++;
            end
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 12));
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
